@@ rtl/olist_pkg.sv @@
package olist_pkg;

    // list geometry
    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DATA_W   = 32;

    // field widths on the ports
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int ECNT_W   = 7;

    // request codes
    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_RSVD   = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // entry memory access issued by the sequencer for one cycle
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

@@ rtl/olist_ram.sv @@
module olist_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/olist_ctrl.sv @@
module olist_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request beat
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic [olist_pkg::OP_W-1:0]     req_op,
    input  logic [olist_pkg::DATA_W-1:0]   req_value,
    // result beat
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic [olist_pkg::STATUS_W-1:0] rsp_status,
    output logic [olist_pkg::ECNT_W-1:0]   rsp_count,
    // entry memory
    output olist_pkg::mem_req_t            mem_req,
    input  logic [olist_pkg::DATA_W-1:0]   mem_rdata
);

    import olist_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t              state_reg;
    op_t                 op_reg;
    logic [DATA_W-1:0]   val_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    count_reg;
    status_t             status_reg;
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [ECNT_W-1:0]   out_count_reg;

    logic                accept;
    logic                out_free;
    logic                is_full;
    logic                is_empty;
    logic [CNT_W-1:0]    idx_inc;
    logic [CNT_W-1:0]    idx_dec;
    op_t                 in_op;

    assign in_op     = op_t'(req_op);
    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_free  = !out_valid_reg || rsp_ready;
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign idx_inc   = idx_reg + 1'b1;
    assign idx_dec   = idx_reg - 1'b1;

    // memory port: append writes at the tail, scan streams reads, shift reads and writes back
    always_comb begin
        mem_req       = '0;
        mem_req.wdata = req_value;
        mem_req.waddr = count_reg[ADDR_W-1:0];
        case (state_reg)
            S_IDLE: begin
                mem_req.we    = accept && (in_op == OP_APPEND) && !is_full;
                mem_req.raddr = '0;
            end
            S_SCAN: begin
                mem_req.raddr = idx_inc[ADDR_W-1:0];
            end
            S_SHIFT: begin
                // move the entry arriving now one place down
                mem_req.we    = (idx_reg != count_reg);
                mem_req.waddr = idx_dec[ADDR_W-1:0];
                mem_req.wdata = mem_rdata;
                mem_req.raddr = idx_inc[ADDR_W-1:0];
            end
            default: begin
                mem_req.raddr = '0;
            end
        endcase
    end

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            // a new result reloads the register in S_DONE instead
            if (out_valid_reg && rsp_ready && (state_reg != S_DONE)) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        op_reg  <= in_op;
                        val_reg <= req_value;
                        idx_reg <= '0;
                        case (in_op)
                            OP_APPEND: begin
                                if (is_full) begin
                                    status_reg <= ST_FULL;
                                end else begin
                                    status_reg <= ST_DONE;
                                    count_reg  <= count_reg + 1'b1;
                                end
                                state_reg <= S_DONE;
                            end
                            OP_SEARCH, OP_DELETE: begin
                                if (is_empty) begin
                                    status_reg <= (in_op == OP_DELETE) ? ST_EMPTY
                                                                       : ST_NOT_FOUND;
                                    state_reg  <= S_DONE;
                                end else begin
                                    state_reg  <= S_SCAN;
                                end
                            end
                            default: begin
                                status_reg <= ST_NOT_FOUND;
                                state_reg  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // data of entry idx_reg is on the read port
                    if (mem_rdata == val_reg) begin
                        status_reg <= ST_DONE;
                        if (op_reg == OP_DELETE) begin
                            idx_reg   <= idx_inc;
                            state_reg <= S_SHIFT;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end else if (idx_inc == count_reg) begin
                        status_reg <= ST_NOT_FOUND;
                        state_reg  <= S_DONE;
                    end else begin
                        idx_reg <= idx_inc;
                    end
                end
                S_SHIFT: begin
                    if (idx_reg == count_reg) begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_DONE;
                    end else begin
                        idx_reg <= idx_inc;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_count_reg  <= ECNT_W'(count_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign rsp_status = out_status_reg;
    assign rsp_count  = out_count_reg;

endmodule

@@ rtl/ordered_list_append_search_delete_top.sv @@
// Ordered list of signed 32-bit values held in insertion order.
// Request channel (s_): s_tuser carries the opcode (append, search,
// delete first match), s_tdata the 32-bit value. One beat per request.
// Result channel (m_): one beat per request; m_tdata carries the status
// code and the entry count held after the request.
// Requests are handled one at a time; s_tready is high only while the
// block is idle. Steps from the request beat to the result beat:
//   append, reserved opcode, or any request on an empty list: no scan
//   search: a scan of up to count stored entries, one compared per cycle
//   delete: the scan up to the match followed by moving each later
//           entry one place down, one per cycle, to close the gap
// A new request is taken from the cycle after the result is registered,
// so even back-to-back appends do not overlap. The walk is set
// by the single read and single write port of the entry memory.
// A finished result sits in an output register; while the receiver
// stalls, the next request is still taken and worked on, and its result
// waits until the register is free.
// Reset clears the entry count and the result valid flag; the entry
// memory is not cleared, and entries beyond the count are never used.
module ordered_list_append_search_delete_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [7:0]  s_tuser,   // [1:0] opcode, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [8:2] entry_count, rest zero
);

    import olist_pkg::*;

    mem_req_t            mem_req;
    logic [DATA_W-1:0]   mem_rdata;
    logic [STATUS_W-1:0] rsp_status;
    logic [ECNT_W-1:0]   rsp_count;

    olist_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req_op     (s_tuser[OP_W-1:0]),
        .req_value  (s_tdata),
        .rsp_valid  (m_tvalid),
        .rsp_ready  (m_tready),
        .rsp_status (rsp_status),
        .rsp_count  (rsp_count),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    olist_ram #(
        .WIDTH  (DATA_W),
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_entries (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    assign m_tdata = {7'b0, rsp_count, rsp_status};

endmodule

@@ rtl/olist_checker.sv @@
module olist_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    import olist_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one request at a time: busy right after a request beat
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // full status only with the list at capacity
    a_full_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == ST_FULL) |-> m_tdata[8:2] == ECNT_W'(CAPACITY))
        else $error("full status with count below capacity");

    // empty status only with no entries
    a_empty_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == ST_EMPTY) |-> m_tdata[8:2] == '0)
        else $error("empty status with entries held");

    // no result right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind ordered_list_append_search_delete_top olist_checker u_olist_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
